// ----- rtl/pcxrle_pkg.sv -----
// Shared types and constants of the PCX run-length scanline decoder.
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned REG_W = 13;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned PIX_W = 8;

  localparam logic [PIX_W-1:0] RUN_MARK   = 8'hC0;
  localparam logic [PIX_W-1:0] COUNT_MASK = 8'h3F;

  typedef enum logic [2:0] {
    REG_ACTIVE_WIDTH = 3'd0,
    REG_LINE_BYTES   = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_THREE_PLANES = 3'd3
  } reg_idx_t;

  // One decoded request: a pixel byte repeated over consecutive columns.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [REG_W-1:0] col;
    logic [REG_W-1:0] row;
    logic [1:0]       plane;
    logic             err;
    logic             img_end;
    logic [CNT_W-1:0] left;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/pcxrle_emit.sv -----
// Run expander: holds one decoded run and plays it out into the result register.
`default_nettype none

module pcxrle_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              flush,
  input  wire logic              job_load,
  input  wire pcxrle_pkg::job_t  job_in,
  output logic                   job_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_pixel_value,
  output logic [11:0]            out_column,
  output logic [11:0]            out_row,
  output logic [1:0]             out_plane,
  output logic                   out_status,
  output logic                   out_last_of_run,
  output logic                   out_image_end
);

  logic              job_valid_r, job_valid_nxt;
  pcxrle_pkg::job_t  job_r, job_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        pix_r;
  logic [11:0]       col_r;
  logic [11:0]       row_r;
  logic [1:0]        plane_r;
  logic              status_r;
  logic              last_r;
  logic              end_r;
  logic              slot_free;
  logic              fire;
  logic              final_beat;

  assign slot_free  = !out_valid_r || out_ready;
  assign fire       = job_valid_r && slot_free;
  assign final_beat = (job_r.left == pcxrle_pkg::CNT_W'(1));
  assign job_ready  = !job_valid_r || (fire && final_beat);

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      job_nxt.left  = job_r.left - pcxrle_pkg::CNT_W'(1);
      job_nxt.col   = job_r.col + pcxrle_pkg::REG_W'(1);
      if (final_beat) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (job_load) begin
      job_valid_nxt = 1'b1;
      job_nxt       = job_in;
    end
    if (flush) begin
      job_valid_nxt = 1'b0;
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (fire) begin
      pix_r    <= job_r.pix;
      col_r    <= job_r.col[11:0];
      row_r    <= job_r.row[11:0];
      plane_r  <= job_r.plane;
      status_r <= job_r.err;
      last_r   <= final_beat;
      // Image end can only fall on the last visible pixel of a run.
      end_r    <= job_r.img_end && final_beat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = pix_r;
  assign out_column      = col_r;
  assign out_row         = row_r;
  assign out_plane       = plane_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;
  assign out_image_end   = end_r;

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (job_r.left != '0))
    else $error("held run has no pixels left");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (last_r && !end_r))
    else $error("corrupt result must close its run and never end the image");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n || flush)
    (job_valid_r && !slot_free) |=> (job_valid_r && $stable(job_r.left)))
    else $error("run advanced while result register was blocked");

endmodule

`default_nettype wire

// ----- rtl/pcx_rle_scanline_decoder_top.sv -----
// Top level of the PCX 8-bit run-length scanline decoder.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_code_byte
//   out_     output     out_valid / out_ready pixel, column, row, plane, flags
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// A literal byte is loaded into the held run when the request is accepted and
// its pixel then goes to the result register. A run of N visible pixels occupies
// the run expander, one result per cycle while the result side does not stall;
// input is held off until its final pixel. Headers, zero runs, padding and
// ignored bytes give no result. Reset is synchronous; a write to a known
// register restarts decoding; result-side stalls hold the expander and input.
`default_nettype none

module pcx_rle_scanline_decoder_top #(
  parameter int unsigned MAX_LINE_BYTES = 4096,
  parameter int unsigned MAX_LINES      = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_code_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_pixel_value,
  output logic [11:0]      out_column,
  output logic [11:0]      out_row,
  output logic [1:0]       out_plane,
  output logic             out_status,
  output logic             out_last_of_run,
  output logic             out_image_end,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  localparam logic [12:0] LB_CAP = 13'(MAX_LINE_BYTES);
  localparam logic [12:0] H_CAP  = 13'(MAX_LINES);

  logic [12:0] aw_cfg_r, aw_cfg_nxt;
  logic [12:0] lb_cfg_r, lb_cfg_nxt;
  logic [12:0] h_cfg_r, h_cfg_nxt;
  logic        tp_cfg_r, tp_cfg_nxt;

  logic        pend_r, pend_nxt;
  logic [5:0]  run_len_r, run_len_nxt;
  logic [12:0] bp_r, bp_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [12:0] line_r, line_nxt;
  logic        err_seen_r, err_seen_nxt;
  logic        img_done_r, img_done_nxt;

  logic [12:0] lb, h, aw, room;
  logic [1:0]  last_plane;
  logic        take, blocked, is_hdr, emit_path, corrupt, visible, restart;
  logic        last_line, reach_end, job_load, job_ready;
  logic [5:0]  cnt, nvis;
  logic [13:0] sum;
  logic [12:0] line_inc;
  pcxrle_pkg::job_t job;

  assign lb = (32'(lb_cfg_r) > MAX_LINE_BYTES) ? LB_CAP : lb_cfg_r;
  assign h  = (32'(h_cfg_r) > MAX_LINES) ? H_CAP : h_cfg_r;
  assign aw = (aw_cfg_r > lb) ? lb : aw_cfg_r;
  assign last_plane = tp_cfg_r ? 2'd2 : 2'd0;

  assign take      = in_valid && in_ready;
  assign blocked   = err_seen_r || img_done_r;
  assign is_hdr    = (in_code_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
  assign cnt       = pend_r ? run_len_r : 6'd1;
  assign emit_path = take && !blocked && (pend_r || !is_hdr) && (cnt != '0);
  assign sum       = {1'b0, bp_r} + 14'(cnt);
  assign corrupt   = sum > {1'b0, lb};
  assign visible   = bp_r < aw;
  assign room      = aw - bp_r;
  assign nvis      = (room >= 13'(cnt)) ? cnt : room[5:0];
  assign reach_end = sum >= {1'b0, aw};
  assign last_line = (h != '0) && (line_r == h - 13'd1) && (plane_r == last_plane);
  assign line_inc  = line_r + 13'd1;

  assign job_load = emit_path && (corrupt || visible);

  always_comb begin
    job.pix     = corrupt ? 8'h00 : in_code_byte;
    job.col     = bp_r;
    job.row     = line_r;
    job.plane   = plane_r;
    job.err     = corrupt;
    job.img_end = !corrupt && reach_end && last_line;
    job.left    = corrupt ? 6'd1 : nvis;
  end

  // Configuration decode; only known registers restart decoding.
  always_comb begin
    aw_cfg_nxt = aw_cfg_r;
    lb_cfg_nxt = lb_cfg_r;
    h_cfg_nxt  = h_cfg_r;
    tp_cfg_nxt = tp_cfg_r;
    restart    = 1'b0;
    if (cfg_wr_en) begin
      unique case (pcxrle_pkg::reg_idx_t'(cfg_index))
        pcxrle_pkg::REG_ACTIVE_WIDTH: begin
          aw_cfg_nxt = cfg_wdata;
          restart    = 1'b1;
        end
        pcxrle_pkg::REG_LINE_BYTES: begin
          lb_cfg_nxt = cfg_wdata;
          restart    = 1'b1;
        end
        pcxrle_pkg::REG_IMAGE_HEIGHT: begin
          h_cfg_nxt = cfg_wdata;
          restart   = 1'b1;
        end
        pcxrle_pkg::REG_THREE_PLANES: begin
          tp_cfg_nxt = cfg_wdata[0];
          restart    = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    pend_nxt     = pend_r;
    run_len_nxt  = run_len_r;
    bp_nxt       = bp_r;
    plane_nxt    = plane_r;
    line_nxt     = line_r;
    err_seen_nxt = err_seen_r;
    img_done_nxt = img_done_r;
    if (restart) begin
      pend_nxt     = 1'b0;
      run_len_nxt  = '0;
      bp_nxt       = '0;
      plane_nxt    = '0;
      line_nxt     = '0;
      err_seen_nxt = 1'b0;
      img_done_nxt = 1'b0;
    end else if (take && !blocked) begin
      if (pend_r) begin
        pend_nxt    = 1'b0;
        run_len_nxt = '0;
      end else if (is_hdr) begin
        pend_nxt    = 1'b1;
        run_len_nxt = 6'(in_code_byte & pcxrle_pkg::COUNT_MASK);
      end
      if (emit_path) begin
        if (corrupt) begin
          err_seen_nxt = 1'b1;
        end else if (sum >= {1'b0, lb}) begin
          bp_nxt = '0;
          if (plane_r >= last_plane) begin
            plane_nxt = '0;
            line_nxt  = line_inc;
            if (line_inc >= h) begin
              img_done_nxt = 1'b1;
            end
          end else begin
            plane_nxt = plane_r + 2'd1;
          end
        end else begin
          bp_nxt = sum[12:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_cfg_r   <= 13'd1;
      lb_cfg_r   <= 13'd1;
      h_cfg_r    <= 13'd1;
      tp_cfg_r   <= 1'b0;
      pend_r     <= 1'b0;
      run_len_r  <= '0;
      bp_r       <= '0;
      plane_r    <= '0;
      line_r     <= '0;
      err_seen_r <= 1'b0;
      img_done_r <= 1'b0;
    end else begin
      aw_cfg_r   <= aw_cfg_nxt;
      lb_cfg_r   <= lb_cfg_nxt;
      h_cfg_r    <= h_cfg_nxt;
      tp_cfg_r   <= tp_cfg_nxt;
      pend_r     <= pend_nxt;
      run_len_r  <= run_len_nxt;
      bp_r       <= bp_nxt;
      plane_r    <= plane_nxt;
      line_r     <= line_nxt;
      err_seen_r <= err_seen_nxt;
      img_done_r <= img_done_nxt;
    end
  end

  assign in_ready = job_ready;

  pcxrle_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .flush           (restart),
    .job_load        (job_load),
    .job_in          (job),
    .job_ready       (job_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_plane       (out_plane),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .out_image_end   (out_image_end)
  );

  a_stop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(err_seen_r && img_done_r))
    else $error("corrupt and image done both set");

  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (bp_r == '0) || (bp_r < lb))
    else $error("byte position ran past the line");

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tp_cfg_r && plane_r != 2'd3) || (!tp_cfg_r && plane_r == 2'd0))
    else $error("plane index outside configured plane count");

endmodule

`default_nettype wire

// ----- tb/pcx_rle_scanline_decoder_top_test.sv -----
// Self-checking testbench for the PCX run-length scanline decoder.
`default_nettype none

module pcx_rle_scanline_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_BYTES_CAP = 4096;
  localparam int unsigned LINES_CAP      = 4096;
  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned SETTLE_CYCLES  = 16;
  // Index past the register file; a write there must change nothing.
  localparam logic [2:0]  REG_UNUSED     = 3'd7;

  typedef struct {
    logic [7:0]  pixel_value;
    logic [11:0] column;
    logic [11:0] row;
    logic [1:0]  plane;
    logic        status;
    logic        last_of_run;
    logic        image_end;
  } pixel_t;

  class pixel_scoreboard;
    logic [12:0] width_reg;
    logic [12:0] pitch_reg;
    logic [12:0] height_reg;
    logic        rgb_reg;

    logic        header_seen;
    logic [5:0]  header_count;
    int unsigned cur_col;
    int unsigned cur_plane;
    int unsigned cur_line;
    logic        corrupt;
    logic        done;

    pixel_t      pixels_due[$];
    int unsigned errors;

    function new();
      width_reg  = 13'd1;
      pitch_reg  = 13'd1;
      height_reg = 13'd1;
      rgb_reg    = 1'b0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      header_seen  = 1'b0;
      header_count = '0;
      cur_col      = 0;
      cur_plane    = 0;
      cur_line     = 0;
      corrupt      = 1'b0;
      done         = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] value);
      case (idx)
        pcxrle_pkg::REG_ACTIVE_WIDTH: width_reg = value;
        pcxrle_pkg::REG_LINE_BYTES:   pitch_reg = value;
        pcxrle_pkg::REG_IMAGE_HEIGHT: height_reg = value;
        pcxrle_pkg::REG_THREE_PLANES: rgb_reg = value[0];
        default: return;
      endcase
      restart();
    endfunction

    function int unsigned line_pitch();
      return (pitch_reg > LINE_BYTES_CAP) ? LINE_BYTES_CAP : pitch_reg;
    endfunction

    function void push_pixel(logic [7:0] pix, int unsigned col, logic err, logic fin);
      pixel_t p;
      p.pixel_value = pix;
      p.column      = col[11:0];
      p.row         = cur_line[11:0];
      p.plane       = cur_plane[1:0];
      p.status      = err;
      p.last_of_run = err;
      p.image_end   = fin;
      pixels_due.push_back(p);
    endfunction

    // Works out the pixels caused by one accepted code byte.
    function void note_request(logic [7:0] b);
      int unsigned pitch, lines, vis, planes, count, col, made;
      logic fin;
      pitch  = line_pitch();
      lines  = (height_reg > LINES_CAP) ? LINES_CAP : height_reg;
      vis    = (width_reg > pitch) ? pitch : width_reg;
      planes = rgb_reg ? 3 : 1;
      made   = 0;
      if (corrupt || done) return;
      if (header_seen) begin
        count        = header_count;
        header_seen  = 1'b0;
        header_count = '0;
      end else if ((b & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
        header_seen  = 1'b1;
        header_count = b[5:0] & pcxrle_pkg::COUNT_MASK[5:0];
        return;
      end else begin
        count = 1;
      end
      if (count == 0) return;
      if (count + cur_col > pitch) begin
        corrupt = 1'b1;
        push_pixel(8'h00, cur_col, 1'b1, 1'b0);
        return;
      end
      for (int unsigned i = 0; i < count; i++) begin
        col = cur_col + i;
        if (col < vis) begin
          fin = (lines != 0) && (cur_line == lines - 1) && (cur_plane == planes - 1)
                && (col == vis - 1);
          push_pixel(b, col, 1'b0, fin);
          made++;
        end
      end
      if (made > 0) pixels_due[pixels_due.size()-1].last_of_run = 1'b1;
      cur_col += count;
      if (cur_col >= pitch) begin
        cur_col = 0;
        cur_plane++;
        if (cur_plane >= planes) begin
          cur_plane = 0;
          cur_line++;
          if (cur_line >= lines) done = 1'b1;
        end
      end
    endfunction

    function void compare(string what, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel, value %0d column %0d row %0d plane %0d",
                 $time, got.pixel_value, got.column, got.row, got.plane);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      compare("pixel_value", 12'(want.pixel_value), 12'(got.pixel_value));
      compare("column", want.column, got.column);
      compare("row", want.row, got.row);
      compare("plane", 12'(want.plane), 12'(got.plane));
      compare("status", 12'(want.status), 12'(got.status));
      compare("last_of_run", 12'(want.last_of_run), 12'(got.last_of_run));
      compare("image_end", 12'(want.image_end), 12'(got.image_end));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_code_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_value;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [1:0]  out_plane;
  logic        out_status;
  logic        out_last_of_run;
  logic        out_image_end;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  pixel_scoreboard sb = new();
  int unsigned stim_count = 0;
  int unsigned random_items = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 76;

  pcx_rle_scanline_decoder_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_byte    (in_code_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_plane       (out_plane),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .out_image_end   (out_image_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pixel_value = out_pixel_value;
      got.column      = out_column;
      got.row         = out_row;
      got.plane       = out_plane;
      got.status      = out_status;
      got.last_of_run = out_last_of_run;
      got.image_end   = out_image_end;
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (stim_count < 60) begin
      send_idle_pct = 29;
      recv_idle_pct = 76;
    end else if (stim_count < 120) begin
      send_idle_pct = 76;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_code_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b);
    stim_count++;
  endtask

  task automatic send_run(input int unsigned count, input logic [7:0] data);
    send_byte(pcxrle_pkg::RUN_MARK | 8'(count));
    send_byte(data);
  endtask

  // Lets every expected pixel arrive, then gives the block time to go idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [12:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int unsigned aw, input int unsigned lb,
                            input int unsigned h, input int unsigned rgb);
    write_cfg(pcxrle_pkg::REG_ACTIVE_WIDTH, 13'(aw));
    write_cfg(pcxrle_pkg::REG_LINE_BYTES, 13'(lb));
    write_cfg(pcxrle_pkg::REG_IMAGE_HEIGHT, 13'(h));
    write_cfg(pcxrle_pkg::REG_THREE_PLANES, 13'(rgb));
  endtask

  // One small random image: mostly well-formed literals and runs that fit the
  // line, with some zero runs, stray bytes and runs that overflow the line.
  task automatic random_image();
    int unsigned pick, room, cnt;
    set_config($urandom_range(0, 14), ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
               $urandom_range(0, 4), $urandom_range(0, 1));
    while (random_items < RANDOM_ITEMS && !sb.corrupt && !sb.done) begin
      room = sb.line_pitch() - sb.cur_col;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        random_items++;
        send_byte(8'($urandom_range(0, 8'hBF)));
      end else if (pick < 85 && room > 0) begin
        cnt = $urandom_range(1, (room < 63) ? room : 63);
        random_items += 2;
        send_run(cnt, 8'($urandom_range(0, 255)));
      end else if (pick < 91) begin
        random_items += 2;
        send_run(0, 8'($urandom_range(0, 255)));
      end else if (pick < 97 || room >= 63) begin
        random_items++;
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        cnt = $urandom_range(room + 1, 63);
        random_items += 2;
        send_run(cnt, 8'($urandom_range(0, 255)));
      end
    end
    // Bytes after the image has ended or broken must be dropped.
    if (sb.corrupt || sb.done) begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a one-pixel image that ends on its first literal.
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Two RGB lines with padding, a zero run and a run that overflows a plane.
    set_config(5, 8, 2, 1);
    send_byte(8'h00);
    send_byte(8'hBF);
    send_run(0, 8'h55);
    send_run(3, 8'hFF);
    send_run(3, 8'hC0);
    send_run(8, 8'h12);
    send_run(9, 8'h34);
    send_byte(8'h01);
    drain();

    // Zero height: the image stops after one line and never flags its end.
    set_config(3, 3, 0, 0);
    send_run(3, 8'h77);
    send_byte(8'h10);
    drain();

    // Zero line bytes: any nonzero run is corrupt.
    set_config(2, 0, 1, 0);
    send_run(0, 8'h00);
    send_byte(8'h20);
    drain();

    // Zero active width: bytes are consumed but nothing is visible.
    set_config(0, 2, 1, 0);
    send_byte(8'h40);
    send_byte(8'h80);
    send_byte(8'h3F);
    drain();

    // Active width above the line byte count is cut to the line.
    set_config(6, 3, 1, 1);
    write_cfg(REG_UNUSED, 13'h1FFF);
    for (int p = 0; p < 3; p++) send_run(3, 8'hA5);
    drain();

    // Largest and oversize register values.
    set_config(4096, 8191, 8191, 1);
    for (int r = 0; r < 20; r++) send_run(63, 8'($urandom_range(0, 255)));
    send_byte(8'h2A);
    drain();
    set_config(8191, 4096, 4096, 0);
    send_byte(8'hBF);
    send_run(63, 8'hFF);
    drain();

    while (random_items < RANDOM_ITEMS) random_image();

    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
